[sv/stit_pkg.sv]
package stit_pkg;

   // Table depth; position and count fields are sized for it
   localparam int DEPTH = 16;

   // Entry count and position width, fixed by the result fields
   localparam int CNT_W = 5;

   // Result item is 12 bits of fields, padded to two bytes
   localparam int RSP_TDATA_W = 16;

   // Capacity register value after reset
   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [0:0] {
      REQ_INSERT = 1'b0,
      REQ_DELETE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS,
      ST_PUT,
      ST_DSCAN,
      ST_DSHIFT,
      ST_RESP
   } state_type;

   // Finished result handed from the sequencer to the output register
   typedef struct packed {
      logic [CNT_W-1:0] count_after;
      logic [CNT_W-1:0] position;
      status_type       status;
   } rsp_type;

endpackage

[sv/stit_ram.sv]
module stit_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         ram_ff[waddr] <= wdata;
      end
      rdata_ff <= ram_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/stit_ctrl.sv]
module stit_ctrl #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  stit_pkg::req_kind_type                req_kind,
   input  logic [KEY_WIDTH-1:0]                  req_key,
   input  logic [stit_pkg::CNT_W-1:0]            cap,
   // table memory
   output logic                                  mem_we,
   output logic [$clog2(stit_pkg::DEPTH)-1:0]    mem_waddr,
   output logic [KEY_WIDTH-1:0]                  mem_wdata,
   output logic [$clog2(stit_pkg::DEPTH)-1:0]    mem_raddr,
   input  logic [KEY_WIDTH-1:0]                  mem_rdata,
   // finished result
   output logic                                  done_valid,
   input  logic                                  done_ready,
   output stit_pkg::rsp_type                     done_rsp
);
   import stit_pkg::*;

   localparam int AW = $clog2(DEPTH);

   state_type          state_ff, state_in;
   req_kind_type       kind_ff, kind_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   status_type         status_ff, status_in;
   logic [CNT_W-1:0]   ucap;
   logic [CNT_W-1:0]   last_idx;
   logic               rd_ge_key;
   logic               rd_eq_key;

   // Capacity saturates at the table depth
   assign ucap = (32'(cap) > 32'(DEPTH)) ? CNT_W'(DEPTH) : cap;

   assign last_idx  = cnt_ff - CNT_W'(1);
   assign rd_ge_key = $signed(mem_rdata) >= $signed(key_ff);
   assign rd_eq_key = mem_rdata == key_ff;

   // State and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      cur_ff    <= cur_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
   end

   // Sequencer: one table entry read per cycle, shift written behind the read
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      key_in     = key_ff;
      cnt_in     = cnt_ff;
      cur_in     = cur_ff;
      pos_in     = pos_ff;
      status_in  = status_ff;
      req_ready  = 1'b0;
      done_valid = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = AW'(cur_ff + CNT_W'(1));
      mem_wdata  = mem_rdata;
      mem_raddr  = AW'(cur_ff - CNT_W'(1));

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in = req_kind;
               key_in  = req_key;
               if (req_kind == REQ_INSERT) begin
                  if (cnt_ff >= ucap) begin
                     status_in = STAT_FULL;
                     pos_in    = cnt_ff;
                     state_in  = ST_RESP;
                  end else if (cnt_ff == '0) begin
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = req_key;
                     pos_in    = '0;
                     cnt_in    = CNT_W'(1);
                     status_in = STAT_DONE;
                     state_in  = ST_RESP;
                  end else begin
                     // walk down from the top entry
                     mem_raddr = AW'(last_idx);
                     cur_in    = last_idx;
                     state_in  = ST_INS;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = STAT_NOT_FOUND;
                     pos_in    = '0;
                     state_in  = ST_RESP;
                  end else begin
                     // walk up from entry zero
                     mem_raddr = '0;
                     cur_in    = '0;
                     state_in  = ST_DSCAN;
                  end
               end
            end
         end

         ST_INS: begin
            // entries not less than the key move up by one
            mem_we = 1'b1;
            if (rd_ge_key) begin
               if (cur_ff == '0) begin
                  pos_in   = '0;
                  state_in = ST_PUT;
               end else begin
                  cur_in = cur_ff - CNT_W'(1);
               end
            end else begin
               mem_wdata = key_ff;
               pos_in    = cur_ff + CNT_W'(1);
               cnt_in    = cnt_ff + CNT_W'(1);
               status_in = STAT_DONE;
               state_in  = ST_RESP;
            end
         end

         ST_PUT: begin
            // key goes to the bottom slot
            mem_we    = 1'b1;
            mem_waddr = AW'(pos_ff);
            mem_wdata = key_ff;
            cnt_in    = cnt_ff + CNT_W'(1);
            status_in = STAT_DONE;
            state_in  = ST_RESP;
         end

         ST_DSCAN: begin
            mem_raddr = AW'(cur_ff + CNT_W'(1));
            if (rd_eq_key) begin
               pos_in    = cur_ff;
               status_in = STAT_DONE;
               if (cur_ff == last_idx) begin
                  cnt_in   = last_idx;
                  state_in = ST_RESP;
               end else begin
                  cur_in   = cur_ff + CNT_W'(1);
                  state_in = ST_DSHIFT;
               end
            end else if (cur_ff == last_idx) begin
               status_in = STAT_NOT_FOUND;
               pos_in    = cnt_ff;
               state_in  = ST_RESP;
            end else begin
               cur_in = cur_ff + CNT_W'(1);
            end
         end

         ST_DSHIFT: begin
            // close the gap: entry moves down by one
            mem_raddr = AW'(cur_ff + CNT_W'(1));
            mem_we    = 1'b1;
            mem_waddr = AW'(cur_ff - CNT_W'(1));
            if (cur_ff == last_idx) begin
               cnt_in   = last_idx;
               state_in = ST_RESP;
            end else begin
               cur_in = cur_ff + CNT_W'(1);
            end
         end

         ST_RESP: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign done_rsp.status      = status_ff;
   assign done_rsp.position    = pos_ff;
   assign done_rsp.count_after = cnt_ff;

endmodule

[sv/sorted_table_insert_delete_top.sv]
// Channel | Direction | Handshake          | Content
// req     | in        | req_tvalid/tready  | tuser: req_type, tdata: key
// rsp     | out       | rsp_tvalid/tready  | tdata: status, position, count_after
// csr     | in        | csr_valid/ready    | csr_data: capacity_limit
//
// The single table memory read port walks one entry per cycle, with the shift
// written behind the read; a full or empty-table case goes straight to the
// result without a walk.
// Reset (synchronous, active high) empties the table and sets capacity to 16.
// A finished item sits in the output register; the next request is taken
// while it waits, and a further result holds until rsp_tready frees it.
module sorted_table_insert_delete_top #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,  // [0] req_type
   input  logic [((KEY_WIDTH+7)/8)*8-1:0]      req_tdata,  // key, zero padded
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] status, [6:2] position, [11:7] count_after, upper bits zero
   output logic [stit_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stit_pkg::CNT_W-1:0]          csr_data
);
   import stit_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [CNT_W-1:0]       cap_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [AW-1:0]          mem_raddr;
   logic [KEY_WIDTH-1:0]   mem_wdata;
   logic [KEY_WIDTH-1:0]   mem_rdata;
   logic                   done_valid;
   logic                   done_ready;
   rsp_type                done_rsp;
   req_kind_type           req_kind;

   assign req_kind  = req_kind_type'(req_tuser);
   assign csr_ready = 1'b1;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   stit_ram #(
      .DEPTH (DEPTH),
      .WIDTH (KEY_WIDTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   stit_ctrl #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_kind),
      .req_key    (req_tdata[KEY_WIDTH-1:0]),
      .cap        (cap_ff),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_rsp   (done_rsp)
   );

   // Output register
   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done_valid && done_ready) begin
         rsp_data_ff <= RSP_TDATA_W'(done_rsp);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sv/stit_check.sv]
module stit_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [stit_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import stit_pkg::*;

   logic [1:0]       st;
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] cnt;

   assign st  = rsp_tdata[1:0];
   assign pos = rsp_tdata[6:2];
   assign cnt = rsp_tdata[11:7];

   // A stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result item right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // A failed request reports the count as its position
   a_fail_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (st == STAT_FULL || st == STAT_NOT_FOUND) |-> pos == cnt)
      else $error("failure position differs from count");

   // A done request lies inside the table, and the status code is defined
   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (st == STAT_DONE || st == STAT_FULL || st == STAT_NOT_FOUND) &&
                     (st != STAT_DONE || pos <= cnt))
      else $error("bad status or position");

endmodule

bind sorted_table_insert_delete_top stit_check u_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sorted_table_insert_delete_top_tb.sv]
`timescale 1ns / 1ps

module sorted_table_insert_delete_top_tb;
   import stit_pkg::*;

   localparam int KEY_W       = 32;
   localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
   localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
   localparam int END_WAIT    = 40;

   // Golden copy of the table plus the queue of replies still owed by the block
   class table_checker;
      logic signed [KEY_W-1:0] entries [DEPTH];
      int unsigned             count    = 0;
      logic [CNT_W-1:0]        capacity = CAP_RESET;
      rsp_type                 replies [$];
      int unsigned             errors   = 0;

      function void set_capacity(logic [CNT_W-1:0] value);
         capacity = value;
      endfunction

      // Update the table for one accepted item and queue the reply it owes
      function void apply_request(req_kind_type kind, logic signed [KEY_W-1:0] key);
         rsp_type     r;
         int unsigned p;
         int unsigned i;
         int unsigned usable;
         usable = (capacity > DEPTH) ? DEPTH : capacity;
         p = 0;
         if (kind == REQ_INSERT) begin
            if (count >= usable) begin
               r.status = STAT_FULL;
               p = count;
            end else begin
               // goes ahead of the first entry not less than the key
               while (p < count && entries[p] < key) p++;
               for (i = count; i > p; i--) entries[i] = entries[i-1];
               entries[p] = key;
               count++;
               r.status = STAT_DONE;
            end
         end else begin
            while (p < count && entries[p] != key) p++;
            if (p == count) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               for (i = p; i + 1 < count; i++) entries[i] = entries[i+1];
               count--;
               r.status = STAT_DONE;
            end
         end
         r.position    = CNT_W'(p);
         r.count_after = CNT_W'(count);
         replies.push_back(r);
      endfunction

      function void report(string what, int unsigned want, int unsigned got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      endfunction

      // Compare one accepted reply with the oldest one owed
      function void check_result(logic [RSP_TDATA_W-1:0] data);
         rsp_type got;
         rsp_type want;
         got = rsp_type'(data[11:0]);
         if (replies.size() == 0) begin
            errors++;
            $display("%0t: reply with none expected, expected none, actual 0x%h", $time, data);
            return;
         end
         want = replies.pop_front();
         if (got.status != want.status) report("status", want.status, got.status);
         if (got.position != want.position) report("position", want.position, got.position);
         if (got.count_after != want.count_after)
            report("count_after", want.count_after, got.count_after);
         if (data[RSP_TDATA_W-1:12] != '0) report("pad bits", 0, data[RSP_TDATA_W-1:12]);
      endfunction
   endclass

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic                       req_tuser  = 1'b0;     // [0] req_type
   logic [KEY_W-1:0]           req_tdata  = '0;       // key
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // [1:0] status, [6:2] position, [11:7] count_after
   logic [RSP_TDATA_W-1:0]     rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CNT_W-1:0]           csr_data   = '0;

   table_checker book = new();
   bit           long_hold_go = 1'b0;
   int           burst_left   = 0;
   int           idle_cycles;

   logic signed [KEY_W-1:0] key_pool [7] = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_8000};

   sorted_table_insert_delete_top #(.KEY_WIDTH(KEY_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watch every handshake at the edge: replies first, then items, then csr writes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) book.check_result(rsp_tdata);
         if (req_tvalid && req_tready) book.apply_request(req_kind_type'(req_tuser), req_tdata);
         if (csr_valid && csr_ready) book.set_capacity(csr_data);
      end
   end

   // Receiver: random stall modes, plus one long hold-off on request
   initial begin
      int mode;
      int mode_left;
      int cyc;
      mode = 0;
      mode_left = 0;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(1));
               2: rsp_tready <= ($urandom_range(3) == 0);
               default: rsp_tready <= ((cyc % 8) < 3);
            endcase
         end
      end
   end

   // Watchdog: no handshake of any kind for too long
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Offer one item, hold it until taken, then maybe idle between bursts
   task automatic send_req(req_kind_type kind, logic [KEY_W-1:0] key);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 10);
      end
   endtask

   // Stop offering and wait until every owed reply has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.replies.size() != 0);
   endtask

   task automatic write_capacity(logic [CNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Random traffic; deletes mostly target keys held in the table
   task automatic run_phase(int n_items, int insert_pct);
      int                      k;
      int                      sel;
      bit                      is_ins;
      logic signed [KEY_W-1:0] key;
      for (k = 0; k < n_items; k++) begin
         is_ins = ($urandom_range(99) < insert_pct);
         sel = $urandom_range(99);
         if (!is_ins && book.count > 0 && sel < 60)
            key = book.entries[$urandom_range(book.count - 1)];
         else if (sel < 45)
            key = key_pool[$urandom_range(6)];
         else
            key = $urandom();
         send_req(is_ins ? REQ_INSERT : REQ_DELETE, key);
      end
   endtask

   initial begin
      int               ph;
      logic [CNT_W-1:0] cap;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // delete on empty, extremes, duplicates, delete of missing key
      send_req(REQ_DELETE, 32'h0000_0000);
      send_req(REQ_INSERT, 32'h7FFF_FFFF);
      send_req(REQ_INSERT, 32'h8000_0000);
      send_req(REQ_INSERT, 32'h0000_0000);
      send_req(REQ_INSERT, 32'hFFFF_FFFF);
      send_req(REQ_INSERT, 32'h0000_0000);
      send_req(REQ_INSERT, 32'h0000_0001);
      send_req(REQ_DELETE, 32'h0000_0000);
      send_req(REQ_DELETE, 32'h0000_0005);
      send_req(REQ_DELETE, 32'h7FFF_FFFF);
      send_req(REQ_DELETE, 32'h8000_0000);

      // capacity lowered below the count: full until deletes make room
      drain_results();
      write_capacity(5'd2);
      send_req(REQ_INSERT, 32'h0000_0007);
      send_req(REQ_DELETE, 32'h0000_0001);
      send_req(REQ_INSERT, 32'h0000_0007);
      send_req(REQ_DELETE, 32'h0000_0000);
      send_req(REQ_INSERT, 32'h0000_0007);

      // zero capacity: every insert is full, deletes still work
      drain_results();
      write_capacity(5'd0);
      send_req(REQ_INSERT, 32'h0000_0003);
      send_req(REQ_DELETE, 32'hFFFF_FFFF);
      send_req(REQ_DELETE, 32'hFFFF_FFFF);

      // random phases over capacity settings and insert/delete mixes
      for (ph = 0; ph < 16; ph++) begin
         drain_results();
         case (ph % 4)
            0: cap = 5'd31;
            1: cap = 5'd16;
            2: cap = CNT_W'($urandom_range(0, 31));
            default: cap = ((ph % 8) == 3) ? 5'd0 : 5'd1;
         endcase
         write_capacity(cap);
         if (ph == 1) long_hold_go = 1'b1;
         run_phase(100, ((ph % 3) == 0) ? 80 : (((ph % 3) == 1) ? 25 : 55));
      end

      drain_results();
      repeat (END_WAIT) @(posedge clock);
      if (book.errors == 0 && book.replies.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
